// ----- src/acpiec_pkg.sv -----
// Package for the ACPI embedded controller host interface.
// Holds command codes, status bits, register geometry and the types the other files use.
// Depends on nothing.
package acpiec_pkg;

	// Default depth of the event code queue.
	localparam int unsigned EVENT_DEPTH_DEF = 8;

	// Register space geometry.
	localparam int unsigned REG_DEPTH = 256;
	localparam int unsigned REG_AW    = 8;

	// Status byte bits.
	localparam logic [7:0] ST_OBF     = 8'h01;
	localparam logic [7:0] ST_IBF     = 8'h02;
	localparam logic [7:0] ST_SCI_EVT = 8'h20;

	// Host command codes.
	localparam logic [7:0] CMD_READ  = 8'h80;
	localparam logic [7:0] CMD_WRITE = 8'h81;
	localparam logic [7:0] CMD_QUERY = 8'h84;

	// Access kinds carried by an input item.
	typedef enum logic [1:0] {
		KIND_HOST_READ  = 2'd0,
		KIND_HOST_WRITE = 2'd1,
		KIND_POST_EVENT = 2'd2,
		KIND_UNUSED     = 2'd3
	} kind_t;

	// Port select codes.
	localparam logic PORT_DATA   = 1'b0;
	localparam logic PORT_STATUS = 1'b1;

	// Host transaction phase.
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_RD_ADDR = 2'd1,
		PH_WR_ADDR = 2'd2,
		PH_WR_DATA = 2'd3
	} phase_t;

	// Sequencer state.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Request bundle for the register space memory.
	typedef struct packed {
		logic              rd_en;
		logic [REG_AW-1:0] rd_addr;
		logic              wr_en;
		logic [REG_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
	} rf_req_t;

endpackage

// ----- src/acpiec_regfile.sv -----
// 256-byte register space of the embedded controller, with a registered read.
// Per-entry valid bits make the space read as zero after reset without a clearing pass.
// Depends on acpiec_pkg.
module acpiec_regfile (
	input  logic                clk,
	input  logic                arst_n,
	input  acpiec_pkg::rf_req_t req,
	output logic [7:0]          rdata
);

	logic [7:0]                       mem_q [acpiec_pkg::REG_DEPTH];
	logic [acpiec_pkg::REG_DEPTH-1:0] valid_q;
	logic [7:0]                       rdata_s1;
	logic                             valid_s1;

	// Storage array: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem_q[req.rd_addr];
		end
	end

	// Valid bits are cleared at reset; a written entry becomes valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				valid_s1 <= valid_q[req.rd_addr];
			end
		end
	end

	// An entry never written reads as its reset value of zero.
	assign rdata = valid_s1 ? rdata_s1 : 8'h00;

endmodule

// ----- src/acpi_ec_host_interface_top.sv -----
// Top level of the ACPI embedded controller host interface, device side.
// Depends on acpiec_pkg and acpiec_regfile.
//
// Each item passes through the idle and execute states of the sequencer: when it is accepted
// the register space and the event queue are read at the addresses the item and the current
// state select, and in the execute state the read data is used, state is updated and any write
// goes back to memory. The result then sits in an output register; the next item is accepted
// as soon as the execute state has placed its result, and a stalled output holds the block in
// the execute state. The register space reads as zero after reset through per-entry valid
// bits, so no clearing pass is needed. Events beyond EVENT_DEPTH pending codes are dropped and flagged.
module acpi_ec_host_interface_top #(
	parameter int unsigned EVENT_DEPTH = acpiec_pkg::EVENT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic       port_select,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       event_dropped,
	output logic       ignored
);

	localparam int unsigned IDX_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(EVENT_DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	// Control state.
	acpiec_pkg::state_t state_q, state_d;
	acpiec_pkg::phase_t phase_q, phase_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               obf_q, obf_d;
	logic               out_valid_q, out_valid_d;

	// Payload state.
	logic [7:0] addr_latch_q, addr_latch_d;
	logic [7:0] out_byte_q, out_byte_d;
	logic [7:0] read_data_q, read_data_d;
	logic       dropped_q, dropped_d;
	logic       ignored_q, ignored_d;

	// Item held between the read cycle and the update cycle.
	logic [1:0] kind_s1;
	logic       port_s1;
	logic [7:0] data_s1;

	// Memory interfaces.
	acpiec_pkg::rf_req_t rf_req;
	logic [7:0]          rf_rdata;
	logic [7:0]          evq_mem_q [EVENT_DEPTH];
	logic [7:0]          evq_rdata_s1;
	logic                evq_wr_en;
	logic [IDX_W-1:0]    evq_wr_addr;

	logic             accept;
	logic             done;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] head_inc;

	// A new item is taken only while the sequencer is idle.
	assign in_ready = (state_q == acpiec_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign done     = (state_q == acpiec_pkg::ST_EXEC) && (!out_valid_q || out_ready);

	// Queue index arithmetic, modulo the queue depth.
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_idx = (tail_sum >= SUM_W'(EVENT_DEPTH)) ?
		IDX_W'(tail_sum - SUM_W'(EVENT_DEPTH)) : IDX_W'(tail_sum);
	assign head_inc = (head_q == IDX_W'(EVENT_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	// Register space.
	acpiec_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rf_req),
		.rdata  (rf_rdata)
	);

	// Event queue memory: read the head on accept, write the tail on update.
	always_ff @(posedge clk) begin
		if (evq_wr_en) begin
			evq_mem_q[evq_wr_addr] <= data_s1;
		end
		if (accept) begin
			evq_rdata_s1 <= evq_mem_q[head_q];
		end
	end

	// Capture the item for the update cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			port_s1 <= port_select;
			data_s1 <= write_data;
		end
	end

	// Next state, memory requests and result.
	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		head_d       = head_q;
		count_d      = count_q;
		obf_d        = obf_q;
		out_valid_d  = out_valid_q;
		addr_latch_d = addr_latch_q;
		out_byte_d   = out_byte_q;
		read_data_d  = read_data_q;
		dropped_d    = dropped_q;
		ignored_d    = ignored_q;
		evq_wr_en    = 1'b0;
		evq_wr_addr  = tail_idx;

		rf_req.rd_en   = accept;
		rf_req.rd_addr = write_data;
		rf_req.wr_en   = 1'b0;
		rf_req.wr_addr = addr_latch_q;
		rf_req.wr_data = data_s1;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			acpiec_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = acpiec_pkg::ST_EXEC;
				end
			end
			acpiec_pkg::ST_EXEC: begin
				if (done) begin
					state_d     = acpiec_pkg::ST_IDLE;
					out_valid_d = 1'b1;
					read_data_d = 8'h00;
					dropped_d   = 1'b0;
					ignored_d   = 1'b0;
					unique case (acpiec_pkg::kind_t'(kind_s1))
						acpiec_pkg::KIND_HOST_READ: begin
							if (port_s1 == acpiec_pkg::PORT_STATUS) begin
								read_data_d = (obf_q ? acpiec_pkg::ST_OBF : 8'h00) |
									((count_q != '0) ? acpiec_pkg::ST_SCI_EVT : 8'h00);
							end else begin
								read_data_d = out_byte_q;
								obf_d       = 1'b0;
							end
						end
						acpiec_pkg::KIND_HOST_WRITE: begin
							if (port_s1 == acpiec_pkg::PORT_STATUS) begin
								// A command aborts any transaction in progress.
								phase_d = acpiec_pkg::PH_IDLE;
								unique case (data_s1)
									acpiec_pkg::CMD_READ:  phase_d = acpiec_pkg::PH_RD_ADDR;
									acpiec_pkg::CMD_WRITE: phase_d = acpiec_pkg::PH_WR_ADDR;
									acpiec_pkg::CMD_QUERY: begin
										if (count_q != '0) begin
											out_byte_d = evq_rdata_s1;
											head_d     = head_inc;
											count_d    = count_q - CNT_W'(1);
										end else begin
											out_byte_d = 8'h00;
										end
										obf_d = 1'b1;
									end
									default: ignored_d = 1'b1;
								endcase
							end else begin
								unique case (phase_q)
									acpiec_pkg::PH_RD_ADDR: begin
										addr_latch_d = data_s1;
										out_byte_d   = rf_rdata;
										obf_d        = 1'b1;
										phase_d      = acpiec_pkg::PH_IDLE;
									end
									acpiec_pkg::PH_WR_ADDR: begin
										addr_latch_d = data_s1;
										phase_d      = acpiec_pkg::PH_WR_DATA;
									end
									acpiec_pkg::PH_WR_DATA: begin
										rf_req.wr_en = 1'b1;
										phase_d      = acpiec_pkg::PH_IDLE;
									end
									acpiec_pkg::PH_IDLE: begin
										// A data byte with no command pending is dropped.
										ignored_d = 1'b1;
									end
									default: ignored_d = 1'b1;
								endcase
							end
						end
						acpiec_pkg::KIND_POST_EVENT: begin
							if (count_q < CNT_W'(EVENT_DEPTH)) begin
								evq_wr_en = 1'b1;
								count_d   = count_q + CNT_W'(1);
							end else begin
								dropped_d = 1'b1;
							end
						end
						acpiec_pkg::KIND_UNUSED: begin
							ignored_d = 1'b1;
						end
						default: ignored_d = 1'b1;
					endcase
				end
			end
			default: state_d = acpiec_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= acpiec_pkg::ST_IDLE;
			phase_q      <= acpiec_pkg::PH_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			obf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			addr_latch_q <= 8'h00;
			out_byte_q   <= 8'h00;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			head_q       <= head_d;
			count_q      <= count_d;
			obf_q        <= obf_d;
			out_valid_q  <= out_valid_d;
			addr_latch_q <= addr_latch_d;
			out_byte_q   <= out_byte_d;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (done) begin
			read_data_q <= read_data_d;
			dropped_q   <= dropped_d;
			ignored_q   <= ignored_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign event_dropped = dropped_q;
	assign ignored       = ignored_q;

endmodule
